// ===== hw/rtl/wdraw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdraw_pkg
// Shared command and status codes and field widths for the weighted draw.
// ----------------------------------------------------------------------------
package wdraw_pkg;
   localparam int IdWidth     = 31;
   localparam int StarsWidth  = 3;
   localparam int WeightWidth = 4;
   localparam int RandWidth   = 32;
   localparam int RemWidth    = 9;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_DRAW  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [1:0] REG_WEIGHT_LOW  = 2'd0;
   localparam logic [1:0] REG_WEIGHT_TWO  = 2'd1;
   localparam logic [1:0] REG_WEIGHT_HIGH = 2'd2;
endpackage

// ===== hw/rtl/weighted_draw_without_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_draw_without_replacement
// Roulette-wheel draw without replacement from an ordered pool in memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  cmd, track_id, stars, random_word
// rsp      out        rsp_valid/rsp_stall  picked_id, picked, remaining, status
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// load, clear and rejected items pass from idle through the done state to the
// response. a draw sums weights over one memory read per cycle, reduces the
// random word to its remainder over the total by a restoring divider, walks to
// the hit and compacts behind it, reading each later entry and copying it down.
// reset is synchronous; the pool memory holds no reset. req_stall is high from
// acceptance until the result has been taken; rsp_stall holds the result.
// ----------------------------------------------------------------------------
module weighted_draw_without_replacement #(
   parameter int POOL_DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_cmd,
   input  logic [wdraw_pkg::IdWidth-1:0]           req_track_id,
   input  logic [wdraw_pkg::StarsWidth-1:0]        req_stars,
   input  logic [wdraw_pkg::RandWidth-1:0]         req_random_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [wdraw_pkg::IdWidth-1:0]           rsp_picked_id,
   output logic                                    rsp_picked,
   output logic [wdraw_pkg::RemWidth-1:0]          rsp_remaining,
   output logic [1:0]                              rsp_status,
   input  logic                                    csr_write_enable,
   input  logic [1:0]                              csr_index,
   input  logic [wdraw_pkg::WeightWidth-1:0]       csr_write_data
);
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int TW = CW + wdraw_pkg::WeightWidth;
   localparam int RW = wdraw_pkg::RandWidth;
   localparam int EW = wdraw_pkg::IdWidth + wdraw_pkg::StarsWidth;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SUMRD = 4'd1;
   localparam logic [3:0] S_SUM   = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_WKRD  = 4'd4;
   localparam logic [3:0] S_WALK  = 4'd5;
   localparam logic [3:0] S_CPRD  = 4'd6;
   localparam logic [3:0] S_COPY  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [EW-1:0] pool_mem [POOL_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [TW-1:0] acc_ff, acc_in;
   logic [TW-1:0] total_ff, total_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [TW:0]   rem_ff, rem_in;
   logic [5:0]    bit_ff, bit_in;
   logic [wdraw_pkg::WeightWidth-1:0] wlow_ff, wtwo_ff, whigh_ff;
   logic [wdraw_pkg::IdWidth-1:0] pid_ff, pid_in;
   logic       picked_ff, picked_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [wdraw_pkg::WeightWidth-1:0] wsel;
   logic [TW:0] rem_shift;
   logic [CW-1:0] idx_next;

   always_comb begin
      logic [wdraw_pkg::StarsWidth-1:0] s;
      logic [wdraw_pkg::WeightWidth-1:0] w;
      s = rd_data_ff[wdraw_pkg::StarsWidth-1:0];
      if (s <= 3'd1) w = wlow_ff;
      else if (s == 3'd2) w = wtwo_ff;
      else w = whigh_ff;
      wsel = (w == '0) ? wdraw_pkg::WeightWidth'(1) : w;
   end

   assign idx_next  = idx_ff + CW'(1);
   assign rem_shift = {rem_ff[TW-1:0], quo_ff[RW-1]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= pool_mem[mem_raddr];
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      total_in = total_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      pid_in = pid_ff;
      picked_in = picked_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = {req_track_id, req_stars};
      mem_raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pid_in = '0;
               picked_in = 1'b0;
               status_in = wdraw_pkg::ST_OK;
               idx_in = '0;
               acc_in = '0;
               quo_in = req_random_word;
               state_in = S_DONE;
               case (req_cmd)
                  wdraw_pkg::CMD_LOAD: begin
                     if (count_ff >= CW'(POOL_DEPTH)) begin
                        status_in = wdraw_pkg::ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        count_in = count_ff + CW'(1);
                     end
                  end
                  wdraw_pkg::CMD_DRAW: begin
                     if (count_ff == '0) begin
                        status_in = wdraw_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_SUMRD;
                     end
                  end
                  wdraw_pkg::CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_SUMRD: begin
            idx_in = idx_next;
            state_in = S_SUM;
         end
         S_SUM: begin
            acc_in = acc_ff + TW'(wsel);
            if (idx_ff == count_ff) begin
               total_in = acc_ff + TW'(wsel);
               rem_in = '0;
               bit_in = '0;
               state_in = S_DIV;
            end else begin
               idx_in = idx_next;
            end
         end
         S_DIV: begin
            if (rem_shift >= {1'b0, total_ff}) begin
               rem_in = rem_shift - {1'b0, total_ff};
               quo_in = {quo_ff[RW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[RW-2:0], 1'b0};
            end
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'(RW - 1)) begin
               idx_in = '0;
               acc_in = '0;
               state_in = S_WKRD;
            end
         end
         S_WKRD: begin
            idx_in = idx_next;
            state_in = S_WALK;
         end
         S_WALK: begin
            acc_in = acc_ff + TW'(wsel);
            if (rem_ff[TW-1:0] < acc_ff + TW'(wsel) || idx_ff == count_ff) begin
               pid_in = rd_data_ff[EW-1:wdraw_pkg::StarsWidth];
               picked_in = 1'b1;
               idx_in = idx_ff - CW'(1);
               state_in = S_CPRD;
            end else begin
               idx_in = idx_next;
            end
         end
         S_CPRD: begin
            if (idx_next >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end else begin
               mem_raddr = idx_next[AW-1:0];
               state_in = S_COPY;
            end
         end
         S_COPY: begin
            mem_we = 1'b1;
            mem_wdata = rd_data_ff;
            idx_in = idx_next;
            state_in = S_CPRD;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wlow_ff <= 4'd1;
         wtwo_ff <= 4'd3;
         whigh_ff <= 4'd6;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               wdraw_pkg::REG_WEIGHT_LOW:  wlow_ff <= csr_write_data;
               wdraw_pkg::REG_WEIGHT_TWO:  wtwo_ff <= csr_write_data;
               wdraw_pkg::REG_WEIGHT_HIGH: whigh_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      total_ff <= total_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      pid_ff <= pid_in;
      picked_ff <= picked_in;
      status_ff <= status_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_picked_id = pid_ff;
   assign rsp_picked    = picked_ff;
   assign rsp_remaining = wdraw_pkg::RemWidth'(count_ff);
   assign rsp_status    = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(POOL_DEPTH)) else $error("pool count over depth");
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_RESP) else $error("result outside response state");
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && picked_ff |-> status_ff == wdraw_pkg::ST_OK)
      else $error("pick with error status");
   a_draw_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK && state_in == S_CPRD |=> count_ff != '0)
      else $error("draw from empty pool");
endmodule
